// ----- rtl/ffpa_pkg.sv -----
// Package for the first-fit pool allocator: sizes, command and status codes, states.
// No dependencies.
package ffpa_pkg;
  localparam int MaxSegments = 64;
  localparam int HeaderBytes = 16;
  localparam int PoolReset = 65536;
  localparam int IdxW = $clog2(MaxSegments);
  localparam int CntW = $clog2(MaxSegments + 1);
  localparam int OffW = 21;
  localparam int EntW = 2 * OffW + 1;
  localparam logic [OffW-1:0] PoolLimit = 21'd1048576;
  localparam logic [OffW-1:0] HdrBytes = OffW'(HeaderBytes);

  typedef enum logic {
    CMD_ALLOC = 1'b0, CMD_FREE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NO_FIT = 2'd1, ST_NOT_FOUND = 2'd2, ST_TABLE_FULL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_SHR, S_SHR_W, S_INS, S_FR_NXT, S_FR_NXT_W,
    S_FR_PRV, S_FR_PRV_W, S_SHL, S_SHL_W, S_DONE
  } state_e;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [OffW-1:0] size;
    logic            used;
  } seg_t;
endpackage

// ----- rtl/ffpa_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ffpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/first_fit_pool_allocator.sv -----
// First-fit pool allocator: a sequencer walks the segment table one entry at a time
// (issue read, use data), with one shared adder. Depends on ffpa_pkg and ffpa_ram.
// One request at a time: s_axis_tready stays low until the result beat is taken.
// Reset (rst_ni low, async) restores a 65536-byte pool of one free segment.
module first_fit_pool_allocator import ffpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [20:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // cmd[0], req_bytes[21:1], block_addr[41:22]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], data_addr[21:2]
);
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] k_q, k_d, i_q, i_d;
  cmd_e            cmd_q, cmd_d;
  logic [OffW-1:0] req_q, req_d;
  logic [19:0]     blk_q, blk_d;
  status_e         st_q, st_d;
  logic [19:0]     addr_q, addr_d;
  seg_t            cur_q, cur_d;
  seg_t            seg0_q, seg0_d;
  logic            shl_last_q, shl_last_d;
  logic            ovalid_q, ovalid_d;
  logic            r0_q;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  seg_t            wdata, rdata;
  logic [EntW-1:0] rraw;
  logic [OffW:0]   need;
  logic [OffW-1:0] sum, clamp;
  logic            in_acc, cfg_acc, fit, hit, last;

  // Entry 0 lives in flip-flops, the rest in the RAM
  ffpa_ram #(.Width(EntW), .Depth(MaxSegments)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rraw));
  assign rdata = r0_q ? seg0_q : seg_t'(rraw);

  assign need = {1'b0, req_q} + (OffW+1)'(HeaderBytes);
  assign clamp = (cfg_data_i > PoolLimit) ? PoolLimit : cfg_data_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {2'b0, addr_q, st_q};

  // Entry tests on the data just read
  assign fit = !rdata.used && ({1'b0, rdata.size} >= need);
  assign hit = rdata.used &&
               (({1'b0, rdata.offset} + (OffW+1)'(HeaderBytes)) == {2'b0, blk_q});
  assign last = (k_q + CntW'(1)) >= cnt_q;

  // Shared adder: tail offset on insert, merged size otherwise
  always_comb begin
    if (state_q == S_INS) sum = cur_q.offset + cur_q.size - req_q;
    else sum = cur_q.size + rdata.size + HdrBytes;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(s_axis_tdata[0]) == CMD_ALLOC)
            state_d = (s_axis_tdata[21:1] == '0) ? S_DONE : S_SRCH;
          else
            state_d = (cnt_q == CntW'(1)) ? S_DONE : S_SRCH;
        end
      end
      S_SRCH:     state_d = S_SRCH_W;
      S_SRCH_W: begin
        if (cmd_q == CMD_ALLOC) begin
          if (fit) state_d = (cnt_q >= CntW'(MaxSegments)) ? S_DONE : S_SHR;
          else if (last) state_d = S_DONE;
          else state_d = S_SRCH;
        end else begin
          if (hit) state_d = S_FR_NXT;
          else if (last) state_d = S_DONE;
          else state_d = S_SRCH;
        end
      end
      S_SHR:      state_d = (i_q > k_q + CntW'(1)) ? S_SHR_W : S_INS;
      S_SHR_W:    state_d = S_SHR;
      S_INS:      state_d = S_DONE;
      S_FR_NXT:   state_d = last ? S_FR_PRV : S_FR_NXT_W;
      S_FR_NXT_W: state_d = rdata.used ? S_FR_PRV : S_SHL;
      S_FR_PRV:   state_d = S_FR_PRV_W;
      S_FR_PRV_W: state_d = rdata.used ? S_DONE : S_SHL;
      S_SHL: begin
        if (i_q + CntW'(1) < cnt_q) state_d = S_SHL_W;
        else state_d = shl_last_q ? S_DONE : S_FR_PRV;
      end
      S_SHL_W:    state_d = S_SHL;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cnt_d = cnt_q; k_d = k_q; i_d = i_q; cmd_d = cmd_q; req_d = req_q; blk_d = blk_q;
    st_d = st_q; addr_d = addr_q; cur_d = cur_q; seg0_d = seg0_q;
    shl_last_d = shl_last_q; ovalid_d = ovalid_q;
    we = 1'b0; waddr = '0; wdata = cur_q; raddr = '0;
    if (m_axis_tvalid && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      // Capture the request and pick the first entry to scan
      S_IDLE: if (in_acc) begin
        cmd_d = cmd_e'(s_axis_tdata[0]);
        req_d = s_axis_tdata[21:1];
        blk_d = s_axis_tdata[41:22];
        st_d = ST_OK; addr_d = '0;
        if (cmd_e'(s_axis_tdata[0]) == CMD_ALLOC) begin
          k_d = '0;
          if (s_axis_tdata[21:1] == '0) st_d = ST_NO_FIT;
        end else begin
          k_d = CntW'(1);
          if (cnt_q == CntW'(1)) st_d = ST_NOT_FOUND;
        end
      end
      S_SRCH: raddr = k_q[IdxW-1:0];
      S_SRCH_W: begin
        cur_d = rdata;
        if (cmd_q == CMD_ALLOC) begin
          if (fit) begin
            if (cnt_q >= CntW'(MaxSegments)) st_d = ST_TABLE_FULL;
            i_d = cnt_q;
          end else if (last) st_d = ST_NO_FIT;
          else k_d = k_q + CntW'(1);
        end else begin
          if (hit) cur_d.used = 1'b0;
          else if (last) st_d = ST_NOT_FOUND;
          else k_d = k_q + CntW'(1);
        end
      end
      // Open a slot at k+1: move entries up, top first
      S_SHR: raddr = IdxW'(i_q - CntW'(1));
      S_SHR_W: begin
        we = 1'b1; waddr = i_q[IdxW-1:0]; wdata = rdata; i_d = i_q - CntW'(1);
      end
      // Carve the used segment from the tail; entry k is written back in S_DONE
      S_INS: begin
        we = 1'b1; waddr = IdxW'(k_q + CntW'(1));
        wdata.offset = sum; wdata.size = req_q; wdata.used = 1'b1;
        cur_d.size = cur_q.size - need[OffW-1:0];
        addr_d = 20'(sum + HdrBytes);
        cnt_d = cnt_q + CntW'(1);
      end
      // Merge with a free next neighbor, then drop it
      S_FR_NXT: raddr = IdxW'(k_q + CntW'(1));
      S_FR_NXT_W: if (!rdata.used) begin
        cur_d.size = sum; i_d = k_q + CntW'(1); shl_last_d = 1'b0;
      end
      // Merge into a free previous neighbor, then drop entry k
      S_FR_PRV: raddr = IdxW'(k_q - CntW'(1));
      S_FR_PRV_W: if (!rdata.used) begin
        cur_d = rdata; cur_d.size = sum;
        i_d = k_q; k_d = k_q - CntW'(1); shl_last_d = 1'b1;
      end
      // Close the gap at i: move entries down
      S_SHL: begin
        raddr = IdxW'(i_q + CntW'(1));
        if (i_q + CntW'(1) >= cnt_q) cnt_d = cnt_q - CntW'(1);
      end
      S_SHL_W: begin
        we = 1'b1; waddr = i_q[IdxW-1:0]; wdata = rdata; i_d = i_q + CntW'(1);
      end
      // Write back entry k and present the result
      S_DONE: begin
        ovalid_d = 1'b1;
        if (st_q == ST_OK) begin
          if (k_q == '0) seg0_d = cur_q;
          else begin we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = cur_q; end
        end
      end
      default: ;
    endcase
    // Reinitialize the table on a pool size write
    if (cfg_acc) begin
      cnt_d = CntW'(1);
      seg0_d.offset = '0; seg0_d.used = 1'b0;
      seg0_d.size = (clamp > HdrBytes) ? clamp - HdrBytes : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= CntW'(1); ovalid_q <= 1'b0; r0_q <= 1'b0;
      seg0_q <= '{offset: '0, size: OffW'(PoolReset - HeaderBytes), used: 1'b0};
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d; seg0_q <= seg0_d;
      r0_q <= (raddr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; i_q <= i_d; cmd_q <= cmd_d; req_q <= req_d; blk_q <= blk_d;
    st_q <= st_d; addr_q <= addr_d; cur_q <= cur_d; shl_last_q <= shl_last_d;
  end
endmodule

// ----- rtl/ffpa_checker.sv -----
// Port checker for the first-fit pool allocator, bound to the top level.
// Depends on ffpa_pkg.
module ffpa_checker import ffpa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  // No new beat taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready with pending result");
  // Result held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // Failed requests return a zero address
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[21:2] == '0)
    else $error("address on failure");
  // An accepted beat does not give a result in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("too fast");
endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);
